// ----- sv/nta_pkg.sv -----
// ============================================================================
// nta_pkg: shared definitions for the neighbor table
// Operation and status codes, field widths, reset values and the result
// record that the sequencer hands to the output stage.
// ============================================================================
package nta_pkg;

    // Field widths of the stream items
    localparam int OP_W        = 2;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int CNT_FIELD_W = 7;

    // Byte-aligned widths of the stream data buses
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Defaults
    localparam int                 TABLE_DEPTH_DEF = 16;
    localparam logic [TIME_W-1:0]  AGE_LIMIT_RESET = 32'd30000;
    localparam logic [ID_W-1:0]    OWN_ID_RESET    = 8'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 1'd1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_PRUNE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OWN       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd4;

    // One result item; status sits in the lowest bits when packed
    typedef struct packed {
        logic [CNT_FIELD_W-1:0] entry_count;
        logic [CNT_FIELD_W-1:0] removed_count;
        logic                   found;
        logic [STATUS_W-1:0]    status;
    } nta_result_t;

endpackage

// ----- sv/nta_store.sv -----
// ============================================================================
// nta_store: neighbor entry memory
// Holds the id and the last-seen time of each entry. One write port and one
// read port with registered read data.
// ============================================================================
module nta_store #(
    parameter int DEPTH = nta_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 4
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [nta_pkg::ID_W-1:0]  rd_id,
    output logic [nta_pkg::TIME_W-1:0] rd_seen,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [nta_pkg::ID_W-1:0]  wr_id,
    input  logic [nta_pkg::TIME_W-1:0] wr_seen
);
    import nta_pkg::*;

    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [TIME_W-1:0] seen_mem [DEPTH];
    logic [ID_W-1:0]   rd_id_reg;
    logic [TIME_W-1:0] rd_seen_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]   <= wr_id;
            seen_mem[wr_addr] <= wr_seen;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg   <= id_mem[rd_addr];
            rd_seen_reg <= seen_mem[rd_addr];
        end
    end

    assign rd_id   = rd_id_reg;
    assign rd_seen = rd_seen_reg;

endmodule

// ----- sv/nta_ctrl.sv -----
// ============================================================================
// nta_ctrl: operation sequencer
// Walks the entry memory one entry per cycle with a shared id compare and
// age subtract-compare unit, refreshes, appends or compacts entries, and
// keeps the entry count.
// ============================================================================
module nta_ctrl #(
    parameter int DEPTH = nta_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Operation intake
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [nta_pkg::OP_W-1:0]    op,
    input  logic [nta_pkg::ID_W-1:0]    nbr_id,
    input  logic [nta_pkg::TIME_W-1:0]  now_ms,
    // Configuration
    input  logic [nta_pkg::ID_W-1:0]    own_id,
    input  logic [nta_pkg::TIME_W-1:0]  age_limit,
    // Result handoff
    output logic                        res_valid,
    input  logic                        res_ready,
    output nta_pkg::nta_result_t        res,
    // Memory ports
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [nta_pkg::ID_W-1:0]    rd_id,
    input  logic [nta_pkg::TIME_W-1:0]  rd_seen,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [nta_pkg::ID_W-1:0]    wr_id,
    output logic [nta_pkg::TIME_W-1:0]  wr_seen
);
    import nta_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]    keep_reg, keep_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;

    logic                issue;
    logic                id_hit;
    logic [TIME_W-1:0]   age;
    logic                expired;

    // Shared compare unit: id match and wrapping age against the limit
    assign issue   = (rd_idx_reg < count_reg);
    assign id_hit  = (rd_id == id_reg);
    assign age     = now_reg - rd_seen;
    assign expired = (age > age_limit);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        now_next      = now_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        keep_next     = keep_reg;
        removed_next  = removed_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        item_ready    = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_DONE);
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_id         = id_reg;
        wr_seen       = now_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next      = op;
                    id_next      = nbr_id;
                    now_next     = now_ms;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    keep_next    = '0;
                    removed_next = '0;
                    status_next  = ST_REFRESHED;
                    found_next   = 1'b0;
                    if (op == OP_TOUCH && nbr_id == own_id)
                    begin
                        status_next = ST_OWN;
                        state_next  = S_DONE;
                    end
                    else if (op == OP_ADD && count_reg == DEPTH_C)
                    begin
                        // A full table drops an add before any duplicate check.
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous entry is compared.
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + ONE_C;
                end

                if (pend_reg)
                begin
                    if (op_reg == OP_PRUNE)
                    begin
                        // Keep live entries, packed down to the keep pointer.
                        if (expired)
                        begin
                            removed_next = removed_reg + ONE_C;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = keep_reg[IDX_W-1:0];
                            wr_id     = rd_id;
                            wr_seen   = rd_seen;
                            keep_next = keep_reg + ONE_C;
                        end
                    end
                    else if (id_hit)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                        unique case (op_reg)
                            OP_TOUCH:
                            begin
                                wr_en       = 1'b1;
                                status_next = ST_REFRESHED;
                            end
                            OP_ADD:
                            begin
                                status_next = ST_PRESENT;
                            end
                            OP_QUERY:
                            begin
                                found_next = 1'b1;
                            end
                            OP_PRUNE:
                            begin
                                found_next = 1'b0;
                            end
                        endcase
                    end
                end
                else if (!issue)
                begin
                    // Scan finished without an early exit.
                    state_next = S_DONE;
                    if (op_reg == OP_PRUNE)
                    begin
                        count_next = keep_reg;
                    end
                    else if (op_reg == OP_QUERY)
                    begin
                        found_next = 1'b0;
                    end
                    else if (count_reg < DEPTH_C)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[IDX_W-1:0];
                        count_next  = count_reg + ONE_C;
                        status_next = ST_APPENDED;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        now_reg      <= now_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        keep_reg     <= keep_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    // Result record
    always_comb
    begin
        res.status        = status_reg;
        res.found         = found_reg;
        res.removed_count = CNT_FIELD_W'(removed_reg);
        res.entry_count   = CNT_FIELD_W'(count_reg);
    end

endmodule

// ----- sv/neighbor_table_with_aging.sv -----
// ============================================================================
// neighbor_table_with_aging: neighbor table with timeout aging
// Keeps one node's bounded, ordered list of neighbor ids with last-seen times
// and serves touch, add, query and prune operations.
// ============================================================================
// Usage:
//   The slave stream carries one operation per transfer: opcode, neighbor
//   id and the current time in ms. The master stream returns exactly one
//   result per operation: status, found flag, removed count and entry count.
//   own_id and age_limit_ms use the cfg_we/cfg_index/cfg_wdata port; the user
//   writes them only while no operation is in flight, unchecked by the block.
//   Scan: an operation walks the valid entries one per cycle through the
//   single memory read port before its result is handed to the output
//   register. A touch that hits its own id or an add on a full table
//   skips the scan; a hit during a scan ends it early.
//   Throughput: one operation at a time; the next one is taken as soon as
//   its predecessor's result has moved into the output register.
//   Reset empties the table and restores own_id to 0 and the age limit to
//   30000 ms. When the receiver stalls, the result waits in the output
//   register and one further operation may complete behind it.
// ============================================================================
module neighbor_table_with_aging #(
    parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Operation stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode[1:0], nbr_id[9:2], now_ms[41:10], zero pad[47:42]
    input  logic [nta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[2:0], found[3], removed_count[10:4], entry_count[17:11],
    // zero pad[23:18]
    output logic [nta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [nta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nta_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import nta_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ID_W-1:0]   own_id_reg;
    logic [TIME_W-1:0] age_limit_reg;
    logic              out_valid_reg;
    nta_result_t       out_data_reg;

    logic              res_valid;
    logic              res_ready;
    nta_result_t       res;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_seen;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ID_W-1:0]   wr_id;
    logic [TIME_W-1:0] wr_seen;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= OWN_ID_RESET;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_ID:    own_id_reg    <= cfg_wdata[ID_W-1:0];
                CFG_AGE_LIMIT: age_limit_reg <= cfg_wdata[TIME_W-1:0];
            endcase
        end
    end

    // Sequencer with the shared compare unit
    nta_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .op         (s_axis_tdata[OP_W-1:0]),
        .nbr_id     (s_axis_tdata[OP_W+ID_W-1:OP_W]),
        .now_ms     (s_axis_tdata[OP_W+ID_W+TIME_W-1:OP_W+ID_W]),
        .own_id     (own_id_reg),
        .age_limit  (age_limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_id      (rd_id),
        .rd_seen    (rd_seen),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_id      (wr_id),
        .wr_seen    (wr_seen)
    );

    // Entry memory
    nta_store #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_seen (rd_seen),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_seen (wr_seen)
    );

    // Output register: loads when empty or when its transfer completes
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for neighbor_table_with_aging
// Drives touch, add, query and prune operations over the operation stream,
// predicts every result with a behavioral copy of the neighbor table, and
// compares each result transfer field by field. A short directed table covers
// reset values, the full table and the own id; random phases then sweep the
// own id and the age limit, with bursty input and a stalling result receiver.
// ============================================================================
module testbench;
    import nta_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int DEPTH           = TABLE_DEPTH_DEF;
    localparam int LONG_HOLD       = 400;
    localparam int N_PHASES        = 4;
    localparam int OPS_PER_PHASE   = 300;
    localparam int TAIL_CYCLES     = DEPTH + 8;
    localparam int RUN_LIMIT_NS    = 8_000_000;
    localparam int MAX_PRINTED     = 50;

    // Receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_ONE_IN_4 = 2;
    localparam int RX_SPARSE   = 3;

    // One row of the directed table; reps > 1 repeats the row with id and
    // time stepped by one each time.
    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [ID_W-1:0]        id;
        logic [TIME_W-1:0]      now;
        logic [7:0]             reps;
        logic                   has_fixed;
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [CNT_FIELD_W-1:0] removed;
        logic [CNT_FIELD_W-1:0] count;
    } dir_row_t;

    localparam int DIR_N = 13;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // Empty table straight out of reset
        '{OP_QUERY, 8'h55, 32'd0,          8'd1,  1'b1, ST_REFRESHED, 1'b0, 7'd0, 7'd0},
        // Own id after reset is 0: touch ignores it, add appends it
        '{OP_TOUCH, 8'h00, 32'd5,          8'd1,  1'b1, ST_OWN,       1'b0, 7'd0, 7'd0},
        '{OP_ADD,   8'h00, 32'd10,         8'd1,  1'b1, ST_APPENDED,  1'b0, 7'd0, 7'd1},
        '{OP_TOUCH, 8'hFF, 32'hFFFF_FFFF,  8'd1,  1'b1, ST_APPENDED,  1'b0, 7'd0, 7'd2},
        '{OP_ADD,   8'hFF, 32'd20,         8'd1,  1'b1, ST_PRESENT,   1'b0, 7'd0, 7'd2},
        '{OP_TOUCH, 8'hFF, 32'd100,        8'd1,  1'b1, ST_REFRESHED, 1'b0, 7'd0, 7'd2},
        // Fill the table with ids 1..14
        '{OP_ADD,   8'h01, 32'd20000,      8'd14, 1'b0, ST_REFRESHED, 1'b0, 7'd0, 7'd0},
        // Full table: add of a present id still reports full
        '{OP_ADD,   8'hFF, 32'd20100,      8'd1,  1'b1, ST_FULL,      1'b0, 7'd0, 7'd16},
        '{OP_TOUCH, 8'hFF, 32'd20200,      8'd1,  1'b1, ST_REFRESHED, 1'b0, 7'd0, 7'd16},
        '{OP_TOUCH, 8'h77, 32'd20300,      8'd1,  1'b1, ST_FULL,      1'b0, 7'd0, 7'd16},
        '{OP_QUERY, 8'h0E, 32'd20400,      8'd1,  1'b1, ST_REFRESHED, 1'b1, 7'd0, 7'd16},
        // Age boundary at the reset limit, then a prune that clears all
        '{OP_PRUNE, 8'hAA, 32'd50006,      8'd1,  1'b0, ST_REFRESHED, 1'b0, 7'd0, 7'd0},
        '{OP_PRUNE, 8'h55, 32'hFFFF_FFFF,  8'd1,  1'b0, ST_REFRESHED, 1'b0, 7'd0, 7'd0}
    };

    // Block ports
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    // Behavioral copy of the table and its registers
    logic [ID_W-1:0]        nbr_ids     [DEPTH];
    logic [TIME_W-1:0]      nbr_seen_ms [DEPTH];
    int                     nbr_count   = 0;
    logic [ID_W-1:0]        cur_own_id  = OWN_ID_RESET;
    logic [TIME_W-1:0]      cur_age_limit = AGE_LIMIT_RESET;

    // Results still owed by the block, oldest first
    nta_result_t            pending_results [$];
    int                     ops_sent       = 0;
    int                     results_seen   = 0;
    int                     mismatch_count = 0;
    int                     burst_left     = 0;
    bit                     hold_request   = 1'b0;

    neighbor_table_with_aging #(
        .TABLE_DEPTH   (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 50 MHz clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Applies one operation to the table copy and returns the result it owes.
    function automatic nta_result_t predict_table_op(input logic [OP_W-1:0] op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [TIME_W-1:0] now);
        nta_result_t      res;
        int               pos;
        int               keep;
        logic [TIME_W-1:0] age;
        res = '0;
        pos = -1;
        for (int i = 0; i < nbr_count; i++)
        begin
            if (pos < 0 && nbr_ids[i] == id)
                pos = i;
        end
        case (op)
            OP_TOUCH:
            begin
                if (id == cur_own_id)
                    res.status = ST_OWN;
                else if (pos >= 0)
                begin
                    nbr_seen_ms[pos] = now;
                    res.status = ST_REFRESHED;
                end
                else if (nbr_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    nbr_ids[nbr_count] = id;
                    nbr_seen_ms[nbr_count] = now;
                    nbr_count++;
                    res.status = ST_APPENDED;
                end
            end
            OP_ADD:
            begin
                // The full check comes before the duplicate check
                if (nbr_count >= DEPTH)
                    res.status = ST_FULL;
                else if (pos >= 0)
                    res.status = ST_PRESENT;
                else
                begin
                    nbr_ids[nbr_count] = id;
                    nbr_seen_ms[nbr_count] = now;
                    nbr_count++;
                    res.status = ST_APPENDED;
                end
            end
            OP_QUERY:
                res.found = (pos >= 0);
            default:
            begin
                // Drop aged entries and close the gaps in order
                keep = 0;
                for (int i = 0; i < nbr_count; i++)
                begin
                    age = now - nbr_seen_ms[i];
                    if (age > cur_age_limit)
                        res.removed_count++;
                    else
                    begin
                        nbr_ids[keep] = nbr_ids[i];
                        nbr_seen_ms[keep] = nbr_seen_ms[i];
                        keep++;
                    end
                end
                nbr_count = keep;
            end
        endcase
        res.entry_count = CNT_FIELD_W'(nbr_count);
        return res;
    endfunction

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR %0t ns: result %0d %s: expected %0d, got %0d",
                     $time, results_seen, what, want_v, got_v);
        mismatch_count++;
    endtask

    // Offers one operation and waits for its transfer. Between bursts the
    // sender drops tvalid for a random gap.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now, input bit use_fixed,
                           input nta_result_t fixed_res);
        nta_result_t want;
        s_axis_tdata  <= IN_DATA_W'({now, id, op});
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = predict_table_op(op, id, now);
        if (use_fixed)
            want = fixed_res;
        pending_results.push_back(want);
        ops_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 6);
        end
    endtask

    // Stops offering and waits until every owed result has been taken.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (results_seen < ops_sent)
            @(posedge clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OWN_ID)
            cur_own_id = value[ID_W-1:0];
        else
            cur_age_limit = value;
        @(posedge clk);
    endtask

    // Result receiver: changing stall patterns, plus a long hold on request
    initial
    begin : result_sink
        int rx_mode;
        int rx_left;
        rx_mode = RX_ALWAYS;
        rx_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
                    rx_left = $urandom_range(20, 200);
                end
                rx_left--;
                case (rx_mode)
                    RX_ALWAYS:   m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_ONE_IN_4: m_axis_tready <= (rx_left % 4 == 0);
                    default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge clk)
    begin : result_check
        nta_result_t got;
        nta_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = nta_result_t'(m_axis_tdata[$bits(nta_result_t)-1:0]);
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer, data", 0, 32'(m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.found != want.found)
                    report_mismatch("found", 32'(want.found), 32'(got.found));
                if (got.removed_count != want.removed_count)
                    report_mismatch("removed_count", 32'(want.removed_count),
                                    32'(got.removed_count));
                if (got.entry_count != want.entry_count)
                    report_mismatch("entry_count", 32'(want.entry_count),
                                    32'(got.entry_count));
            end
            results_seen++;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        dir_row_t          row;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   pool_base;
        logic [TIME_W-1:0] clock_ms;
        int                step_max;
        int                sel;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, run on the reset register values
        for (int r = 0; r < DIR_N; r++)
        begin
            row = DIR_ROWS[r];
            for (int k = 0; k < row.reps; k++)
                send_op(row.op, row.id + ID_W'(k), row.now + TIME_W'(k), row.has_fixed,
                        nta_result_t'({row.count, row.removed, row.found, row.status}));
        end
        wait_all_results();

        // Random phases, each with its own registers and time behavior
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_OWN_ID, CFG_DATA_W'(OWN_ID_RESET));
                    write_reg(CFG_AGE_LIMIT, AGE_LIMIT_RESET);
                    step_max = 2000;
                    clock_ms = 32'd100000;
                end
                1:
                begin
                    // Zero limit: only entries seen at exactly now survive
                    write_reg(CFG_OWN_ID, 32'hFF);
                    write_reg(CFG_AGE_LIMIT, 32'd0);
                    step_max = 3;
                    clock_ms = 32'hFFFF_FF00;
                end
                2:
                begin
                    // Largest limit: prune never removes anything
                    write_reg(CFG_OWN_ID, 32'h5A);
                    write_reg(CFG_AGE_LIMIT, 32'hFFFF_FFFF);
                    step_max = 100000;
                    clock_ms = $urandom();
                end
                default:
                begin
                    write_reg(CFG_OWN_ID, $urandom_range(0, 255));
                    write_reg(CFG_AGE_LIMIT, $urandom_range(20, 500));
                    step_max = int'(cur_age_limit) / 8;
                    clock_ms = $urandom();
                end
            endcase
            pool_base = ID_W'($urandom_range(0, 255));

            for (int n = 0; n < OPS_PER_PHASE; n++)
            begin
                // Long receiver hold while the sender keeps offering
                if (ph == 1 && n == 100)
                    hold_request = 1'b1;
                // Sender pause until the block has caught up
                if (ph == 0 && n == 150)
                    wait_all_results();

                sel = $urandom_range(0, 99);
                if (sel < 40)
                    op = OP_TOUCH;
                else if (sel < 60)
                    op = OP_ADD;
                else if (sel < 85)
                    op = OP_QUERY;
                else
                    op = OP_PRUNE;

                // Mostly ids from a small pool so that hits and fills happen
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    id = cur_own_id;
                else if (sel == 1)
                    id = ID_W'($urandom_range(0, 255));
                else
                    id = ID_W'(pool_base + $urandom_range(0, 23));

                if ($urandom_range(0, 39) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));

                send_op(op, id, clock_ms, 1'b0, '0);
            end
            wait_all_results();
        end

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/nta_pkg.sv
sv/nta_store.sv
sv/nta_ctrl.sv
sv/neighbor_table_with_aging.sv
test/testbench.sv
